FILE: src/bre_pkg.sv
// Shared types, constants and helper functions for the bitmap range engine.
// Used by bre_ctrl, bre_datapath and bitmap_range_engine; depends on nothing.
`default_nettype none

package bre_pkg;

    localparam int BIT_W        = 13;
    localparam int WORD_W       = 32;
    localparam int LSB_W        = 5;
    localparam int WIDX_W       = BIT_W - LSB_W;
    localparam int OP_W         = 3;
    localparam int NUM_WORDS_DEF = 256;

    localparam logic [OP_W-1:0] OP_SET        = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE     = 3'd2;
    localparam logic [OP_W-1:0] OP_TEST       = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_SET   = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_CLEAR = 3'd5;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [BIT_W-1:0] start_bit;
        logic [BIT_W-1:0] end_bit;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] position;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic advance;
        logic capture;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish;
    } sts_t;

    // Index of the lowest set bit of a nonzero word.
    function automatic logic [LSB_W-1:0] lowest_bit(input word_t v);
        logic [LSB_W-1:0] idx;
        idx = LSB_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = LSB_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: src/bre_ctrl.sv
// Controller state machine of the bitmap range engine.
// Sequences load, per-word execution and result hand-off; uses bre_pkg.
`default_nettype none

module bre_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire bre_pkg::sts_t sts,
    output bre_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.finish)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_DONE:
            begin
                // The result moves out only once the output slot is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.emit       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: src/bre_datapath.sv
// Datapath of the bitmap range engine: bitmap memory, per-word valid flags,
// range masks, read-modify-write and find logic. Uses bre_pkg.
`default_nettype none

module bre_datapath #(
    parameter int NUM_WORDS = bre_pkg::NUM_WORDS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bre_pkg::req_t req,
    input  wire bre_pkg::cmd_t cmd,
    output bre_pkg::sts_t      sts,
    output bre_pkg::rsp_t      rsp
);

    // Only the first 2**WIDX_W words can ever be addressed.
    localparam int MAX_REACH = 1 << bre_pkg::WIDX_W;
    localparam int MEM_DEPTH = (NUM_WORDS < MAX_REACH) ? NUM_WORDS : MAX_REACH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    bre_pkg::word_t bitmap_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] word_valid_reg;

    logic [bre_pkg::OP_W-1:0]   op_reg;
    logic [bre_pkg::BIT_W-1:0]  start_reg;
    logic [bre_pkg::BIT_W-1:0]  end_reg;
    logic                       bad_reg;
    logic [bre_pkg::WIDX_W-1:0] cur_reg;
    bre_pkg::word_t             rdata_reg;
    logic                       rvld_reg;
    logic                       inr_reg;
    bre_pkg::rsp_t              res_reg;
    bre_pkg::rsp_t              rsp_reg;

    logic [bre_pkg::WIDX_W-1:0] rd_addr;
    logic                       rd_inr;
    logic                       rd_en;
    bre_pkg::word_t             word_v;
    bre_pkg::word_t             mask;
    bre_pkg::word_t             sel;
    bre_pkg::word_t             word_new;
    logic                       is_query;
    logic                       is_modify;
    logic                       found;
    logic                       last;
    logic                       we;
    bre_pkg::rsp_t              res_next;

    assign rd_en   = cmd.load || cmd.advance;
    assign rd_addr = cmd.load ? req.start_bit[bre_pkg::BIT_W-1:bre_pkg::LSB_W]
                              : cur_reg + bre_pkg::WIDX_W'(1);
    assign rd_inr  = (32'(rd_addr) < NUM_WORDS);

    // A word that was never written since reset reads as zero.
    assign word_v = (inr_reg && rvld_reg) ? rdata_reg : '0;

    always_comb
    begin
        mask = '1;
        if (cur_reg == start_reg[bre_pkg::BIT_W-1:bre_pkg::LSB_W])
        begin
            mask = mask & ({bre_pkg::WORD_W{1'b1}} << start_reg[bre_pkg::LSB_W-1:0]);
        end
        if (cur_reg == end_reg[bre_pkg::BIT_W-1:bre_pkg::LSB_W])
        begin
            mask = mask & ({bre_pkg::WORD_W{1'b1}} >> (~end_reg[bre_pkg::LSB_W-1:0]));
        end
    end

    assign sel = (op_reg == bre_pkg::OP_FIND_CLEAR) ? (~word_v & mask) : (word_v & mask);

    assign is_query  = (op_reg == bre_pkg::OP_TEST) || (op_reg == bre_pkg::OP_FIND_SET)
                    || (op_reg == bre_pkg::OP_FIND_CLEAR);
    assign is_modify = (op_reg == bre_pkg::OP_SET) || (op_reg == bre_pkg::OP_CLEAR)
                    || (op_reg == bre_pkg::OP_TOGGLE);
    assign found     = is_query && (sel != '0);
    assign last      = (cur_reg == end_reg[bre_pkg::BIT_W-1:bre_pkg::LSB_W]);

    assign sts.finish = bad_reg || last || found;

    always_comb
    begin
        case (op_reg)
            bre_pkg::OP_SET:    word_new = word_v | mask;
            bre_pkg::OP_CLEAR:  word_new = word_v & ~mask;
            bre_pkg::OP_TOGGLE: word_new = word_v ^ mask;
            default:            word_new = word_v;
        endcase
    end

    assign we = cmd.exec && !bad_reg && inr_reg && is_modify;

    always_comb
    begin
        res_next.hit      = found && !bad_reg;
        res_next.position = '0;
        if (found && !bad_reg && (op_reg != bre_pkg::OP_TEST))
        begin
            res_next.position = {cur_reg, bre_pkg::lowest_bit(sel)};
        end
    end

    // Memory port: one registered read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en && rd_inr)
        begin
            rdata_reg <= bitmap_mem[rd_addr[ADDR_W-1:0]];
        end
        if (we)
        begin
            bitmap_mem[cur_reg[ADDR_W-1:0]] <= word_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rvld_reg       <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvld_reg <= rd_inr && word_valid_reg[rd_addr[ADDR_W-1:0]];
            end
            if (we)
            begin
                word_valid_reg[cur_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req.opcode;
            start_reg <= req.start_bit;
            end_reg   <= req.end_bit;
            bad_reg   <= (req.opcode > bre_pkg::OP_FIND_CLEAR)
                      || (req.start_bit > req.end_bit);
        end
        if (rd_en)
        begin
            cur_reg <= rd_addr;
            inr_reg <= rd_inr;
        end
        if (cmd.capture)
        begin
            res_reg <= res_next;
        end
        if (cmd.emit)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: src/bitmap_range_engine.sv
// Bitmap range engine: set, clear, toggle, test and find-first over bit ranges.
// Each item walks the words of its range (a test or find stops at the first
// matching word; a reversed range or an unused opcode takes one word). One memory
// read-modify-write per word sets the pace; a new item is taken only once the last
// result has moved to the output slot, which waits while the output is stalled.
// Reset clears per-word valid flags at once; no clearing pass is needed.
`default_nettype none

module bitmap_range_engine #(
    parameter int NUM_WORDS = bre_pkg::NUM_WORDS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bre_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bre_pkg::rsp_t      rsp
);

    bre_pkg::cmd_t cmd;
    bre_pkg::sts_t sts;

    bre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bre_datapath #(
        .NUM_WORDS (NUM_WORDS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
